// File: design/qsvf_pkg.sv
package qsvf_pkg;

  localparam int unsigned INPUT_SHIFT = 2;

  localparam int unsigned SW = 16;
  localparam int unsigned MW = 22;
  localparam int unsigned AW = 18;
  localparam int unsigned BW = 20;
  localparam int unsigned DIG = 4;
  localparam int unsigned NDIG = BW / DIG;
  localparam int unsigned CNTW = $clog2(NDIG);
  localparam int unsigned ACCW = AW + DIG + 2;
  localparam int unsigned HW = ACCW - DIG;
  localparam int unsigned QSH = 15;

  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 17;

  localparam logic [CFG_IW-1:0] CFG_DAMPING = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_FREQ    = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] CFG_DRIVE   = CFG_IW'(2);
  localparam logic [CFG_IW-1:0] CFG_MODE    = CFG_IW'(3);

  localparam logic [2:0] MODE_LOW    = 3'd0;
  localparam logic [2:0] MODE_HIGH   = 3'd1;
  localparam logic [2:0] MODE_BAND   = 3'd2;
  localparam logic [2:0] MODE_NOTCH  = 3'd3;
  localparam logic [2:0] MODE_BYPASS = 3'd4;

  localparam logic [16:0] DAMPING_RESET = 17'd19208;
  localparam logic [15:0] FREQ_RESET    = 16'd2144;
  localparam logic [15:0] DRIVE_RESET   = 16'd8192;

  typedef struct packed {
    logic [16:0] damping;
    logic [15:0] freq;
    logic [15:0] drive;
    logic [2:0]  mode;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_DAMP_B,
    OP_FREQ_B,
    OP_FREQ_H,
    OP_B_B,
    OP_B_BB,
    OP_DRIVE_BBB
  } op_e;

  localparam logic signed [MW-1:0] SAT_MAX = MW'(32767);
  localparam logic signed [MW-1:0] SAT_MIN = -MW'(32768);

  function automatic logic signed [SW-1:0] sat16(input logic signed [MW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SAT_MAX) begin
      r = 16'sh7fff;
    end else if (v < SAT_MIN) begin
      r = 16'sh8000;
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SW-1:0] scale_out(input logic signed [SW-1:0] v);
    logic signed [MW-1:0] w;
    w = MW'(v) <<< (INPUT_SHIFT - 1);
    return sat16(w);
  endfunction

endpackage

// File: design/qsvf_serial_mul.sv
module qsvf_serial_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [qsvf_pkg::AW-1:0] a_i,
  input  logic signed [qsvf_pkg::BW-1:0] b_i,
  output logic                          done_o,
  output logic signed [qsvf_pkg::MW-1:0] p_o
);
  import qsvf_pkg::*;

  logic signed [AW-1:0]   a_q;
  logic signed [HW-1:0]   hi_q;
  logic [BW-1:0]          lo_q;
  logic [CNTW-1:0]        cnt_q;
  logic                   busy_q;
  logic                   done_q;

  logic                   last;
  logic signed [DIG:0]    digit;
  logic signed [ACCW-1:0] pp;
  logic signed [ACCW-1:0] sum;

  assign last = (cnt_q == CNTW'(NDIG - 1));

  // top digit carries the sign of the serial operand
  always_comb begin
    digit = last ? {lo_q[DIG-1], lo_q[DIG-1:0]} : {1'b0, lo_q[DIG-1:0]};
    pp    = ACCW'(a_q * digit);
    sum   = ACCW'(hi_q) + pp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNTW'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= HW'(sum >>> DIG);
      lo_q <= {sum[DIG-1:0], lo_q[BW-1:DIG]};
    end
  end

  assign done_o = done_q;
  assign p_o    = {hi_q[MW-(BW-QSH)-1:0], lo_q[BW-1:QSH]};

endmodule

// File: design/qsvf_cfg_regs.sv
module qsvf_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [qsvf_pkg::CFG_IW-1:0]     cfg_index_i,
  input  logic [qsvf_pkg::CFG_DW-1:0]     cfg_data_i,
  output logic                            cfg_ready_o,
  output qsvf_pkg::cfg_t                  cfg_o
);
  import qsvf_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DAMPING: cfg_d.damping = cfg_data_i[16:0];
        CFG_FREQ:    cfg_d.freq    = cfg_data_i[15:0];
        CFG_DRIVE:   cfg_d.drive   = cfg_data_i[15:0];
        CFG_MODE:    cfg_d.mode    = cfg_data_i[2:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.damping <= DAMPING_RESET;
      cfg_q.freq    <= FREQ_RESET;
      cfg_q.drive   <= DRIVE_RESET;
      cfg_q.mode    <= MODE_LOW;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/q15_double_sampled_svf_unit.sv
// each item takes 12 multiplies on the single shared 4-bit-digit serial multiplier
// (two filter passes); a new item is taken only once the last result is loaded
// into the output register
// a finished result waits in the output register while the next item is taken
// reset: asynchronous active low, clears integrators, handshakes and loads
// coefficient defaults
module q15_double_sampled_svf_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [qsvf_pkg::SW-1:0]       sample_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [qsvf_pkg::SW-1:0]       selected_out_o,
  output logic signed [qsvf_pkg::SW-1:0]       low_out_o,
  output logic signed [qsvf_pkg::SW-1:0]       high_out_o,
  output logic signed [qsvf_pkg::SW-1:0]       band_out_o,
  output logic signed [qsvf_pkg::SW-1:0]       notch_out_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [qsvf_pkg::CFG_IW-1:0]          cfg_index_i,
  input  logic [qsvf_pkg::CFG_DW-1:0]          cfg_data_i
);
  import qsvf_pkg::*;

  cfg_t      cfg;
  logic      mul_start;
  logic      mul_done;

  state_e state_q, state_d;
  op_e    op_q;
  logic   pass_q;
  logic   out_valid_q;
  logic   accept;
  logic   load_out;
  logic   wb;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [MW-1:0] mul_p;

  logic signed [SW-1:0] x_q;
  logic signed [SW-1:0] low_q, band_q, notch_q, high_q;
  logic signed [MW-1:0] n_q, l_q, h_q, acc_q, bb_q, bbb_q;
  logic signed [MW-1:0] l_d, nb_d;
  logic signed [SW-1:0] sel_d;

  logic signed [SW-1:0] sel_q, lo_out_q, hi_out_q, bd_out_q, nt_out_q;

  qsvf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  qsvf_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  always_comb begin
    mul_a = AW'(band_q);
    mul_b = BW'(band_q);
    case (op_q)
      OP_DAMP_B: begin
        mul_a = AW'(cfg.damping);
        mul_b = BW'(band_q);
      end
      OP_FREQ_B: begin
        mul_a = AW'(cfg.freq);
        mul_b = BW'(band_q);
      end
      OP_FREQ_H: begin
        mul_a = AW'(cfg.freq);
        mul_b = h_q[BW-1:0];
      end
      OP_B_B: begin
        mul_a = AW'(band_q);
        mul_b = BW'(band_q);
      end
      OP_B_BB: begin
        mul_a = AW'(band_q);
        mul_b = bb_q[BW-1:0];
      end
      OP_DRIVE_BBB: begin
        mul_a = AW'(cfg.drive);
        mul_b = bbb_q[BW-1:0];
      end
      default: begin
        mul_a = AW'(band_q);
        mul_b = BW'(band_q);
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    mul_start  = 1'b0;
    load_out   = 1'b0;
    wb         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        mul_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_done) begin
          wb = 1'b1;
          if (op_q == OP_DRIVE_BBB && pass_q) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_START;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_DAMP_B;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
      low_q       <= '0;
      band_q      <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        op_q   <= OP_DAMP_B;
        pass_q <= 1'b0;
      end else if (wb) begin
        if (op_q == OP_DRIVE_BBB) begin
          op_q   <= OP_DAMP_B;
          pass_q <= 1'b1;
          low_q  <= sat16(l_q);
          band_q <= sat16(nb_d);
        end else begin
          op_q <= op_e'(3'(op_q) + 3'd1);
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign l_d  = MW'(low_q) + mul_p;
  assign nb_d = acc_q - mul_p;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= sample_in_i >>> INPUT_SHIFT;
    end
    if (wb) begin
      case (op_q)
        OP_DAMP_B:    n_q   <= MW'(x_q) - mul_p;
        OP_FREQ_B: begin
          l_q <= l_d;
          h_q <= n_q - l_d;
        end
        OP_FREQ_H:    acc_q <= mul_p + MW'(band_q);
        OP_B_B:       bb_q  <= mul_p;
        OP_B_BB:      bbb_q <= mul_p;
        OP_DRIVE_BBB: begin
          notch_q <= sat16(n_q);
          high_q  <= sat16(h_q);
        end
        default: n_q <= n_q;
      endcase
    end
  end

  always_comb begin
    case (cfg.mode)
      MODE_LOW:    sel_d = scale_out(low_q);
      MODE_HIGH:   sel_d = scale_out(high_q);
      MODE_BAND:   sel_d = scale_out(band_q);
      MODE_NOTCH:  sel_d = scale_out(notch_q);
      MODE_BYPASS: sel_d = x_q;
      default:     sel_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      sel_q    <= sel_d;
      lo_out_q <= scale_out(low_q);
      hi_out_q <= scale_out(high_q);
      bd_out_q <= scale_out(band_q);
      nt_out_q <= scale_out(notch_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign selected_out_o = sel_q;
  assign low_out_o      = lo_out_q;
  assign high_out_o     = hi_out_q;
  assign band_out_o     = bd_out_q;
  assign notch_out_o    = nt_out_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input taken while a sample is in flight");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_WAIT)
    else $error("multiplier result arrived outside wait state");

  a_out_after_two_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |-> pass_q)
    else $error("result formed before second pass");

  a_no_start_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |=> !mul_start)
    else $error("multiplier restarted back to back");
`endif

endmodule
